// ===== sv/cbm_pkg.sv =====
// Shared types and constants for the cartridge bank mapper.
package cbm_pkg;

  localparam int ADDR_W       = 16;
  localparam int DATA_W       = 8;
  localparam int ROM_BANK_W   = 9;
  localparam int BANK_COUNT_W = 10;
  localparam int RAM_BANK_W   = 4;
  localparam int RAM_SIZE_W   = 16;
  localparam int RAM_OFS_W    = 13;
  localparam int ROM_OFS_W    = 14;
  localparam int RAM_FULL_W   = RAM_BANK_W + RAM_OFS_W;
  localparam int ROM_ADDR_W   = ROM_BANK_W + ROM_OFS_W;
  localparam int CFG_INDEX_W  = 1;
  localparam int CFG_DATA_W   = 16;

  // Remainder unit: bits of the bank retired per cycle.
  localparam int MOD_STEPS  = 3;
  localparam int MOD_CYCLES = ROM_BANK_W / MOD_STEPS;
  localparam int MOD_CNT_W  = $clog2(MOD_CYCLES);

  localparam logic [CFG_INDEX_W-1:0] CFG_ROM_BANK_COUNT = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_RAM_SIZE_BYTES = 1'd1;

  localparam logic [1:0] ST_DONE     = 2'd0;
  localparam logic [1:0] ST_RAM_FAIL = 2'd1;
  localparam logic [1:0] ST_UNMAPPED = 2'd2;

  localparam logic [DATA_W-1:0] NO_ANSWER  = 8'hFF;
  localparam logic [3:0]        RAM_ON_KEY = 4'hA;

  localparam logic [BANK_COUNT_W-1:0] RESET_BANK_COUNT = 10'd2;
  localparam logic [ROM_BANK_W-1:0]   RESET_ROM_BANK   = 9'd1;

  typedef struct packed {
    logic                    start;
    logic [ROM_BANK_W-1:0]   dividend;
    logic [BANK_COUNT_W-1:0] divisor;
  } cbm_mod_req_t;

  typedef struct packed {
    logic                  done;
    logic [ROM_BANK_W-1:0] rem;
  } cbm_mod_rsp_t;

endpackage

// ===== sv/cbm_ram.sv =====
// Single-port banked cartridge RAM with registered read data.
module cbm_ram
  import cbm_pkg::*;
#(
  parameter int DEPTH = 32768,
  parameter int AW    = 15
) (
  input  logic              clk,
  input  logic              we,
  input  logic              re,
  input  logic [AW-1:0]     addr,
  input  logic [DATA_W-1:0] wdata,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

// ===== sv/cbm_mod.sv =====
// Bank remainder unit: restoring remainder, MOD_STEPS bits of the bank per cycle.
module cbm_mod
  import cbm_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  cbm_mod_req_t req,
  output cbm_mod_rsp_t rsp
);

  logic                    busy;
  logic [MOD_CNT_W-1:0]    cnt;
  logic [ROM_BANK_W-1:0]   dvd;
  logic [BANK_COUNT_W-1:0] dsr;
  logic [ROM_BANK_W-1:0]   rem;
  logic [ROM_BANK_W-1:0]   rem_next;
  logic                    done;

  always_comb begin
    logic [BANK_COUNT_W-1:0] t;
    rem_next = rem;
    for (int i = 0; i < MOD_STEPS; i++) begin
      t = {rem_next, dvd[ROM_BANK_W-1-i]};
      if (t >= dsr) begin
        t = t - dsr;
      end
      rem_next = t[ROM_BANK_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
        rem  <= '0;
        dvd  <= req.dividend;
        dsr  <= req.divisor;
      end else if (busy) begin
        rem <= rem_next;
        dvd <= dvd << MOD_STEPS;
        cnt <= cnt + 1'b1;
        if (cnt == MOD_CNT_W'(MOD_CYCLES - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done;
  assign rsp.rem  = rem;

endmodule

// ===== sv/cartridge_bank_mapper.sv =====
// Top level of the cartridge bank mapper: decode, bank registers and result register.
//
// One bus access is handled at a time. A ROM read, an unmapped access, a RAM
// write or a control write passes from S_EXEC straight to S_DONE, which loads
// the result register. A RAM read that passes the enable and size checks reads
// the internal RAM and passes through S_RAMRD for the registered memory read.
// A ROM bank write with a nonzero bank count runs the remainder unit, 3 bits of
// the bank per cycle, in S_MOD before S_DONE. The next access is taken the
// cycle after the current one has reached the result register; the result
// waits in S_DONE while the output is stalled. RAM contents are undefined
// until written; there is no clearing pass after reset. The configuration
// port is always ready and is meant to be written only while no access is in
// flight.
module cartridge_bank_mapper
  import cbm_pkg::*;
#(
  parameter int RAM_BYTES = 32768
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic                   kind,
  input  logic [ADDR_W-1:0]      address,
  input  logic [DATA_W-1:0]      write_data,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [DATA_W-1:0]      read_data,
  output logic                   rom_fetch,
  output logic [ROM_ADDR_W-1:0]  rom_address,
  output logic [1:0]             status,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int RAM_AW = $clog2(RAM_BYTES);
  localparam logic [RAM_FULL_W:0] RAM_LIMIT = (RAM_FULL_W + 1)'(RAM_BYTES);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_EXEC  = 3'd1;
  localparam logic [2:0] S_MOD   = 3'd2;
  localparam logic [2:0] S_RAMRD = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [2:0] state;

  logic [BANK_COUNT_W-1:0] rom_bank_count;
  logic [RAM_SIZE_W-1:0]   ram_size_bytes;
  logic                    ram_on;
  logic [ROM_BANK_W-1:0]   rom_bank;
  logic [RAM_BANK_W-1:0]   ram_bank;

  // Latched access
  logic              acc_write;
  logic [ADDR_W-1:0] acc_addr;
  logic [DATA_W-1:0] acc_data;

  // Pending result
  logic [DATA_W-1:0]     res_rd;
  logic                  res_fetch;
  logic [ROM_ADDR_W-1:0] res_raddr;
  logic [1:0]            res_status;

  // Decoded result of the latched access
  logic [DATA_W-1:0]     dec_rd;
  logic                  dec_fetch;
  logic [ROM_ADDR_W-1:0] dec_raddr;
  logic [1:0]            dec_status;
  logic [2:0]            dec_state;

  logic                  ram_we;
  logic                  ram_re;
  logic [DATA_W-1:0]     ram_q;
  logic [RAM_FULL_W-1:0] ram_full;
  logic                  ram_ok;
  logic                  in_ram;
  logic                  out_free;
  logic [ROM_BANK_W-1:0] rom_bank_next;
  logic                  bank_write;

  cbm_mod_req_t mod_req;
  cbm_mod_rsp_t mod_rsp;

  assign in_stall  = (state != S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid || !out_stall;

  assign ram_full = {ram_bank, acc_addr[RAM_OFS_W-1:0]};
  assign in_ram   = (acc_addr[15:13] == 3'b101);
  assign ram_ok   = ram_on && (ram_size_bytes != '0)
                  && ({1'b0, ram_full} < (RAM_FULL_W + 1)'(ram_size_bytes))
                  && ({1'b0, ram_full} < RAM_LIMIT);

  assign bank_write = (state == S_EXEC) && acc_write
                    && ((acc_addr[15:12] == 4'h2) || (acc_addr[15:12] == 4'h3));
  assign rom_bank_next = (acc_addr[15:12] == 4'h2) ? {rom_bank[8], acc_data}
                                                    : {acc_data[0], rom_bank[7:0]};

  assign ram_we = (state == S_EXEC) && acc_write && in_ram && ram_ok;
  assign ram_re = (state == S_EXEC) && !acc_write && in_ram && ram_ok;

  assign mod_req.start    = bank_write && (rom_bank_count != '0);
  assign mod_req.dividend = rom_bank_next;
  assign mod_req.divisor  = rom_bank_count;

  always_comb begin
    dec_rd     = '0;
    dec_fetch  = 1'b0;
    dec_raddr  = '0;
    dec_status = ST_DONE;
    dec_state  = S_DONE;
    if (!acc_write) begin
      priority if (acc_addr[15:14] == 2'b00) begin
        dec_fetch = 1'b1;
        dec_raddr = ROM_ADDR_W'(acc_addr);
      end else if (acc_addr[15:14] == 2'b01) begin
        // Switched bank must lie inside the ROM present.
        if ({1'b0, rom_bank} < rom_bank_count) begin
          dec_fetch = 1'b1;
          dec_raddr = {rom_bank, acc_addr[ROM_OFS_W-1:0]};
        end else begin
          dec_rd     = NO_ANSWER;
          dec_status = ST_UNMAPPED;
        end
      end else if (in_ram) begin
        if (ram_ok) begin
          dec_state = S_RAMRD;
        end else begin
          dec_rd     = NO_ANSWER;
          dec_status = ST_RAM_FAIL;
        end
      end else begin
        dec_rd     = NO_ANSWER;
        dec_status = ST_UNMAPPED;
      end
    end else begin
      unique case (acc_addr[15:13])
        3'b000, 3'b010: ;
        3'b001: begin
          // Wrap the new bank unless the bank count is zero
          if (rom_bank_count != '0) begin
            dec_state = S_MOD;
          end
        end
        3'b101: begin
          if (!ram_ok) begin
            dec_status = ST_RAM_FAIL;
          end
        end
        default: dec_status = ST_UNMAPPED;
      endcase
    end
  end

  cbm_ram #(
    .DEPTH (RAM_BYTES),
    .AW    (RAM_AW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .re    (ram_re),
    .addr  (ram_full[RAM_AW-1:0]),
    .wdata (acc_data),
    .rdata (ram_q)
  );

  cbm_mod u_mod (
    .clk (clk),
    .rst (rst),
    .req (mod_req),
    .rsp (mod_rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      rom_bank_count <= RESET_BANK_COUNT;
      ram_size_bytes <= '0;
      ram_on         <= 1'b0;
      rom_bank       <= RESET_ROM_BANK;
      ram_bank       <= '0;
      out_valid      <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_ROM_BANK_COUNT: rom_bank_count <= cfg_data[BANK_COUNT_W-1:0];
          CFG_RAM_SIZE_BYTES: ram_size_bytes <= cfg_data[RAM_SIZE_W-1:0];
          default: ;
        endcase
      end

      if ((state == S_DONE) && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            acc_write <= kind;
            acc_addr  <= address;
            acc_data  <= write_data;
            state     <= S_EXEC;
          end
        end
        S_EXEC: begin
          res_rd     <= dec_rd;
          res_fetch  <= dec_fetch;
          res_raddr  <= dec_raddr;
          res_status <= dec_status;
          state      <= dec_state;
          if (acc_write && (acc_addr[15:13] == 3'b000)) begin
            ram_on <= (acc_data[3:0] == RAM_ON_KEY);
          end
          if (bank_write && (rom_bank_count == '0)) begin
            rom_bank <= rom_bank_next;
          end
          if (acc_write && (acc_addr[15:13] == 3'b010)) begin
            ram_bank <= acc_data[RAM_BANK_W-1:0];
          end
        end
        S_MOD: begin
          if (mod_rsp.done) begin
            rom_bank <= mod_rsp.rem;
            state    <= S_DONE;
          end
        end
        S_RAMRD: begin
          res_rd <= ram_q;
          state  <= S_DONE;
        end
        S_DONE: begin
          // Hold the result until the output register frees up.
          if (out_free) begin
            read_data   <= res_rd;
            rom_fetch   <= res_fetch;
            rom_address <= res_raddr;
            status      <= res_status;
            state       <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_mod_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == S_MOD) |-> (rom_bank_count != '0))
    else $error("remainder unit running with zero bank count");

  a_mod_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_MOD && mod_rsp.done) |-> ({1'b0, mod_rsp.rem} < rom_bank_count))
    else $error("bank remainder not below bank count");

  a_accept_exec: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> (state == S_EXEC))
    else $error("accepted beat did not start execution");

  a_out_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == S_DONE))
    else $error("result presented without a finished access");

endmodule

// ===== tb/cartridge_bank_mapper_chk.sv =====
// Result checker for the cartridge bank mapper: tracks bank state and compares each result beat.
module cartridge_bank_mapper_chk
  import cbm_pkg::*;
#(
  parameter int RAM_BYTES = 32768
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  input  logic                   in_stall,
  input  logic                   kind,
  input  logic [ADDR_W-1:0]      address,
  input  logic [DATA_W-1:0]      write_data,
  input  logic                   out_valid,
  input  logic                   out_stall,
  input  logic [DATA_W-1:0]      read_data,
  input  logic                   rom_fetch,
  input  logic [ROM_ADDR_W-1:0]  rom_address,
  input  logic [1:0]             status,
  input  logic                   cfg_valid,
  input  logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output int                     mismatch_count,
  output int                     results_owed
);

  localparam int ROM_BANK_BYTES = 16384;
  localparam int RAM_AW         = $clog2(RAM_BYTES);

  typedef struct packed {
    logic [DATA_W-1:0]     rd;
    logic                  fetch;
    logic [ROM_ADDR_W-1:0] raddr;
    logic [1:0]            st;
  } bus_result_t;

  bus_result_t owed_results[$];

  logic [BANK_COUNT_W-1:0] bank_count;
  logic [RAM_SIZE_W-1:0]   ram_size;
  logic                    ram_on;
  logic [ROM_BANK_W-1:0]   rom_bank;
  logic [RAM_BANK_W-1:0]   ram_bank;
  logic [DATA_W-1:0]       ram_bytes [0:RAM_BYTES-1];

  function automatic logic [ROM_BANK_W-1:0] wrapped_bank(input logic [ROM_BANK_W-1:0] b);
    logic [BANK_COUNT_W-1:0] rem;
    if (bank_count == '0) return b;
    rem = {1'b0, b} % bank_count;
    return rem[ROM_BANK_W-1:0];
  endfunction

  task automatic decode_access(input logic wr, input logic [ADDR_W-1:0] a,
                               input logic [DATA_W-1:0] d, output bus_result_t r);
    int unsigned ram_idx;
    int unsigned rom_lin;
    logic        ram_ok;
    r       = '0;
    ram_idx = (int'(ram_bank) << RAM_OFS_W) + int'(a[RAM_OFS_W-1:0]);
    rom_lin = int'(rom_bank) * ROM_BANK_BYTES + int'(a[ROM_OFS_W-1:0]);
    ram_ok  = ram_on && (ram_size != '0) && (ram_idx < int'(ram_size)) && (ram_idx < RAM_BYTES);
    if (!wr) begin
      if (a <= 16'h3FFF) begin
        r.fetch = 1'b1;
        r.raddr = ROM_ADDR_W'(a);
      end else if (a <= 16'h7FFF) begin
        if (rom_lin < int'(bank_count) * ROM_BANK_BYTES) begin
          r.fetch = 1'b1;
          r.raddr = ROM_ADDR_W'(rom_lin);
        end else begin
          r.rd = NO_ANSWER;
          r.st = ST_UNMAPPED;
        end
      end else if (a >= 16'hA000 && a <= 16'hBFFF) begin
        if (ram_ok) begin
          r.rd = ram_bytes[RAM_AW'(ram_idx)];
        end else begin
          r.rd = NO_ANSWER;
          r.st = ST_RAM_FAIL;
        end
      end else begin
        r.rd = NO_ANSWER;
        r.st = ST_UNMAPPED;
      end
    end else begin
      if (a <= 16'h1FFF) begin
        ram_on = (d[3:0] == RAM_ON_KEY);
      end else if (a <= 16'h2FFF) begin
        rom_bank = wrapped_bank({rom_bank[ROM_BANK_W-1], d});
      end else if (a <= 16'h3FFF) begin
        rom_bank = wrapped_bank({d[0], rom_bank[ROM_BANK_W-2:0]});
      end else if (a <= 16'h5FFF) begin
        ram_bank = d[RAM_BANK_W-1:0];
      end else if (a >= 16'hA000 && a <= 16'hBFFF) begin
        if (ram_ok) ram_bytes[RAM_AW'(ram_idx)] = d;
        else r.st = ST_RAM_FAIL;
      end else begin
        r.st = ST_UNMAPPED;
      end
    end
  endtask

  always @(posedge clk) begin
    bus_result_t want;
    bus_result_t got;
    logic        bad;
    if (rst) begin
      bank_count = RESET_BANK_COUNT;
      ram_size   = '0;
      ram_on     = 1'b0;
      rom_bank   = RESET_ROM_BANK;
      ram_bank   = '0;
      owed_results.delete();
      mismatch_count = 0;
      results_owed   = 0;
    end else begin
      // Retire the result beat first; it always belongs to an older access.
      if (out_valid && !out_stall) begin
        got = {read_data, rom_fetch, rom_address, status};
        if (owed_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("%0t: result beat with nothing owed: rd=%h fetch=%b raddr=%h st=%0d",
                     $time, got.rd, got.fetch, got.raddr, got.st);
        end else begin
          want = owed_results.pop_front();
          bad  = (got.rd !== want.rd) || (got.fetch !== want.fetch) ||
                 (got.raddr !== want.raddr) || (got.st !== want.st);
          if (bad) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("%0t: mismatch rd %h/%h fetch %b/%b raddr %h/%h st %0d/%0d (exp/act)",
                       $time, want.rd, got.rd, want.fetch, got.fetch,
                       want.raddr, got.raddr, want.st, got.st);
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_ROM_BANK_COUNT) bank_count = cfg_data[BANK_COUNT_W-1:0];
        else ram_size = cfg_data[RAM_SIZE_W-1:0];
      end
      if (in_valid && !in_stall) begin
        decode_access(kind, address, write_data, want);
        owed_results.push_back(want);
      end
      results_owed = owed_results.size();
    end
  end

endmodule

// ===== tb/cartridge_bank_mapper_tb.sv =====
// Testbench top for the cartridge bank mapper: clock, reset, bus and register stimulus, verdict.
module cartridge_bank_mapper_tb;
  import cbm_pkg::*;

  localparam int   RAM_BYTES   = 32768;
  localparam int   RAM_AW      = $clog2(RAM_BYTES);
  localparam int   CYCLE_LIMIT = 400000;
  localparam int   LONG_HOLD   = 400;
  localparam logic ACC_READ    = 1'b0;
  localparam logic ACC_WRITE   = 1'b1;

  logic                   clk = 1'b0;
  logic                   rst;
  logic                   in_valid;
  logic                   in_stall;
  logic                   kind;
  logic [ADDR_W-1:0]      address;
  logic [DATA_W-1:0]      write_data;
  logic                   out_valid;
  logic                   out_stall;
  logic [DATA_W-1:0]      read_data;
  logic                   rom_fetch;
  logic [ROM_ADDR_W-1:0]  rom_address;
  logic [1:0]             status;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  int mismatch_count;
  int results_owed;
  int cycle_count = 0;
  bit calm;
  bit hold_req;

  // Stimulus-side view of RAM, only to keep reads off bytes never written.
  logic                  m_ram_on;
  logic [RAM_BANK_W-1:0] m_ram_bank;
  int unsigned           m_ram_size;
  bit                    written [0:RAM_BYTES-1];

  cartridge_bank_mapper #(.RAM_BYTES(RAM_BYTES)) u_top (
    .clk, .rst, .in_valid, .in_stall, .kind, .address, .write_data,
    .out_valid, .out_stall, .read_data, .rom_fetch, .rom_address, .status,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  cartridge_bank_mapper_chk #(.RAM_BYTES(RAM_BYTES)) u_chk (
    .clk, .rst, .in_valid, .in_stall, .kind, .address, .write_data,
    .out_valid, .out_stall, .read_data, .rom_fetch, .rom_address, .status,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .mismatch_count, .results_owed
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("cartridge_bank_mapper_tb: errors");
      $finish;
    end
  end

  task automatic send_beat(input logic k, input logic [ADDR_W-1:0] a, input logic [DATA_W-1:0] d);
    int pause;
    pause = calm ? 0 : $urandom_range(0, 19);
    @(negedge clk);
    if (pause > 0) begin
      in_valid <= 1'b0;
      repeat (pause) @(negedge clk);
    end
    kind       <= k;
    address    <= a;
    write_data <= d;
    in_valid   <= 1'b1;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic bus_access(input logic k, input logic [ADDR_W-1:0] a, input logic [DATA_W-1:0] d);
    int unsigned idx;
    logic        hit;
    idx = (int'(m_ram_bank) << RAM_OFS_W) + int'(a[RAM_OFS_W-1:0]);
    hit = (a >= 16'hA000) && (a <= 16'hBFFF) && m_ram_on && (m_ram_size != 0) &&
          (idx < m_ram_size) && (idx < RAM_BYTES);
    // turn a read of a fresh byte into the write that fills it
    if (k == ACC_READ && hit && !written[RAM_AW'(idx)]) k = ACC_WRITE;
    if (k == ACC_WRITE) begin
      if (a <= 16'h1FFF) m_ram_on = (d[3:0] == RAM_ON_KEY);
      else if (a >= 16'h4000 && a <= 16'h5FFF) m_ram_bank = d[RAM_BANK_W-1:0];
      else if (hit) written[RAM_AW'(idx)] = 1'b1;
    end
    send_beat(k, a, d);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Drop valid, wait for every owed result, then let the block sit idle.
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (results_owed != 0) @(negedge clk);
    repeat (10) @(negedge clk);
  endtask

  task automatic set_config(input int count, input int size);
    settle();
    write_reg(CFG_ROM_BANK_COUNT, CFG_DATA_W'(count));
    write_reg(CFG_RAM_SIZE_BYTES, CFG_DATA_W'(size));
    m_ram_size = size;
  endtask

  task automatic random_access();
    int          pick;
    logic        k;
    logic [15:0] a;
    logic [7:0]  d;
    logic [12:0] ofs;
    pick = $urandom_range(0, 99);
    k    = ACC_WRITE;
    d    = 8'($urandom_range(0, 255));
    ofs  = ($urandom_range(0, 9) < 7) ? 13'($urandom_range(0, 63))
                                      : 13'($urandom_range(0, 16'h1FFF));
    if (pick < 6) begin
      a = 16'($urandom_range(0, 16'h1FFF));
      if ($urandom_range(0, 3) != 0) d[3:0] = RAM_ON_KEY;
    end else if (pick < 12) begin
      a = 16'($urandom_range(16'h2000, 16'h2FFF));
    end else if (pick < 16) begin
      a = 16'($urandom_range(16'h3000, 16'h3FFF));
    end else if (pick < 22) begin
      a = 16'($urandom_range(16'h4000, 16'h5FFF));
      if ($urandom_range(0, 9) < 7) d[3:0] = 4'($urandom_range(0, 3));
    end else if (pick < 42) begin
      a = 16'hA000 + ofs;
    end else if (pick < 62) begin
      k = ACC_READ;
      a = 16'hA000 + ofs;
    end else if (pick < 72) begin
      k = ACC_READ;
      a = 16'($urandom_range(0, 16'h3FFF));
    end else if (pick < 82) begin
      k = ACC_READ;
      a = 16'($urandom_range(16'h4000, 16'h7FFF));
    end else if (pick < 88) begin
      k = 1'($urandom_range(0, 1));
      case ($urandom_range(0, 2))
        0:       a = 16'($urandom_range(16'h8000, 16'h9FFF));
        1:       a = 16'($urandom_range(16'hC000, 16'hFFFF));
        default: a = k ? 16'($urandom_range(16'h6000, 16'h7FFF))
                       : 16'($urandom_range(16'h8000, 16'h9FFF));
      endcase
    end else begin
      k = 1'($urandom_range(0, 1));
      a = 16'($urandom_range(0, 16'hFFFF));
    end
    bus_access(k, a, d);
  endtask

  task automatic random_run(input int n);
    for (int i = 0; i < n; i++) begin
      if (i > 0 && i % 40 == 0) calm = ($urandom_range(0, 3) == 0);
      random_access();
    end
  endtask

  // Receiver: random hold-off per beat, plus one long hold on request.
  initial begin
    int hold;
    bit long_done;
    forever begin
      @(negedge clk);
      if (hold_req && !long_done) begin
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(negedge clk);
        long_done = 1'b1;
      end else begin
        hold = calm ? 0 : $urandom_range(0, 19);
        if (hold > 0) begin
          out_stall <= 1'b1;
          repeat (hold) @(negedge clk);
        end
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  initial begin
    rst        = 1'b1;
    in_valid   = 1'b0;
    kind       = ACC_READ;
    address    = '0;
    write_data = '0;
    out_stall  = 1'b0;
    cfg_valid  = 1'b0;
    cfg_index  = CFG_ROM_BANK_COUNT;
    cfg_data   = '0;
    calm       = 1'b0;
    hold_req   = 1'b0;
    m_ram_on   = 1'b0;
    m_ram_bank = '0;
    m_ram_size = 0;
    repeat (12) @(negedge clk);
    rst <= 1'b0;

    // Reset settings: two ROM banks, no RAM.
    set_config(2, 0);
    bus_access(ACC_READ,  16'h0000, 8'h00);
    bus_access(ACC_READ,  16'h3FFF, 8'h00);
    bus_access(ACC_READ,  16'h4000, 8'h00);
    bus_access(ACC_READ,  16'h7FFF, 8'h00);
    bus_access(ACC_READ,  16'h8000, 8'h00);
    bus_access(ACC_READ,  16'h9FFF, 8'h00);
    bus_access(ACC_READ,  16'hC000, 8'h00);
    bus_access(ACC_READ,  16'hFFFF, 8'h00);
    bus_access(ACC_READ,  16'hA000, 8'h00);
    bus_access(ACC_WRITE, 16'hBFFF, 8'h55);
    bus_access(ACC_WRITE, 16'h6000, 8'h12);
    bus_access(ACC_WRITE, 16'hFFFF, 8'hFF);
    bus_access(ACC_WRITE, 16'h1FFF, 8'hFA);
    bus_access(ACC_WRITE, 16'hA000, 8'h33);
    bus_access(ACC_READ,  16'hBFFF, 8'h00);
    bus_access(ACC_WRITE, 16'h2000, 8'hFF);
    bus_access(ACC_WRITE, 16'h3FFF, 8'h01);
    bus_access(ACC_READ,  16'h4000, 8'h00);
    bus_access(ACC_WRITE, 16'h5FFF, 8'hFF);
    bus_access(ACC_WRITE, 16'h4000, 8'h00);
    bus_access(ACC_WRITE, 16'h0000, 8'h0B);
    random_run(60);

    // Largest ROM and RAM: bank edges and the top of RAM.
    set_config(512, 32768);
    bus_access(ACC_WRITE, 16'h0000, 8'h0A);
    bus_access(ACC_WRITE, 16'hA000, 8'h00);
    bus_access(ACC_READ,  16'hA000, 8'h00);
    bus_access(ACC_WRITE, 16'h4000, 8'h03);
    bus_access(ACC_WRITE, 16'hBFFF, 8'hFF);
    bus_access(ACC_READ,  16'hBFFF, 8'h00);
    bus_access(ACC_WRITE, 16'h4000, 8'h04);
    bus_access(ACC_READ,  16'hA000, 8'h00);
    bus_access(ACC_WRITE, 16'hA000, 8'h5A);
    bus_access(ACC_WRITE, 16'h4000, 8'h00);
    random_run(120);
    bus_access(ACC_WRITE, 16'h2000, 8'hFF);
    bus_access(ACC_WRITE, 16'h3000, 8'h01);
    bus_access(ACC_READ,  16'h7FFF, 8'h00);
    bus_access(ACC_READ,  16'h4000, 8'h00);

    // Shrink the ROM under a high bank: switched reads fall past the end.
    set_config(4, 32768);
    bus_access(ACC_READ,  16'h4000, 8'h00);
    bus_access(ACC_READ,  16'h7FFF, 8'h00);
    bus_access(ACC_WRITE, 16'h2000, 8'h06);
    bus_access(ACC_READ,  16'h4000, 8'h00);
    calm = 1'b1;
    random_run(80);

    // Zero bank count: no wrap, every switched read out of range.
    calm = 1'b0;
    set_config(0, 8192);
    bus_access(ACC_WRITE, 16'h2000, 8'h05);
    bus_access(ACC_READ,  16'h4000, 8'h00);
    bus_access(ACC_READ,  16'h7FFF, 8'h00);
    bus_access(ACC_READ,  16'h0000, 8'h00);
    random_run(100);

    set_config(1, 3000);
    random_run(100);

    // Long receiver hold while the sender keeps offering beats.
    set_config($urandom_range(1, 512), $urandom_range(0, 32768));
    hold_req = 1'b1;
    random_run(100);

    set_config(300, 1);
    random_run(90);

    settle();
    if (mismatch_count == 0 && results_owed == 0)
      $display("cartridge_bank_mapper_tb: clean");
    else
      $display("cartridge_bank_mapper_tb: errors");
    $finish;
  end

endmodule
